// File: rtl/dll_pkg.sv
package dll_pkg;

  localparam int POOL_NODES_DEF = 256;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed field widths of the request and result beats
  localparam int REQ_W    = 3;
  localparam int HANDLE_W = 8;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT     = 3'd0,
    REQ_ERASE      = 3'd1,
    REQ_PUSH_BACK  = 3'd2,
    REQ_PUSH_FRONT = 3'd3,
    REQ_POP_BACK   = 3'd4,
    REQ_POP_FRONT  = 3'd5,
    REQ_PEEK_BACK  = 3'd6,
    REQ_PEEK_FRONT = 3'd7
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  // node store write strobes
  typedef struct packed {
    logic value_we;
    logic use_we;
    logic use_bit;
    logic next_we;
    logic prev_we;
  } wr_t;

  // free pool strobes
  typedef struct packed {
    logic pop;
    logic push;
  } pool_ctl_t;

endpackage

// File: rtl/doubly_linked_list_engine.sv
// Result: out_valid rises when the request finishes in CHK (in WR for a successful insert
//   or push), held back only while the output register stays full.
// A new request is taken only in IDLE, once the last one is done; WR of an insert or push is the
//   neighbor link update on the single write port of each link memory.
// Reset: synchronous, active low; clears sentinel links, counts and handshake state.
//   No clearing pass: never-used nodes are tracked by the free stack's low mark.
module doubly_linked_list_engine #(
  parameter int POOL_NODES = dll_pkg::POOL_NODES_DEF,
  parameter int DATA_WIDTH = dll_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dll_pkg::REQ_W-1:0]    in_req_type,
  input  logic [dll_pkg::HANDLE_W-1:0] in_node_handle,
  input  logic [dll_pkg::WORD_W-1:0]   in_data_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dll_pkg::STATUS_W-1:0] out_status,
  output logic [dll_pkg::WORD_W-1:0]   out_data_out,
  output logic [dll_pkg::HANDLE_W-1:0] out_result_handle,
  output logic                         out_is_empty,
  output logic [dll_pkg::COUNT_W-1:0]  out_element_count
);
  import dll_pkg::*;

  localparam int AW = $clog2(POOL_NODES);

  // sequencer: IDLE takes a beat and launches the node read, CHK decides, does the node-local
  // writes and the unlink of an erase or pop, WR finishes the neighbor links of an insert or push
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CHK  = 3'b010,
    S_WR   = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  req_t                  req_r;
  logic [HANDLE_W-1:0]   h_r;
  logic [DATA_WIDTH-1:0] data_r;
  logic [AW-1:0]         pos_r;
  logic [AW-1:0]         n_r;
  logic [AW-1:0]         before_r;
  logic [AW-1:0]         size_r, size_nxt;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic [WORD_W-1:0]     out_data_r;
  logic [HANDLE_W-1:0]   out_handle_r;
  logic                  out_empty_r;
  logic [COUNT_W-1:0]    out_count_r;

  // node store
  logic                  accept;
  logic [AW-1:0]         pos_in;
  wr_t                   wr;
  logic [AW-1:0]         node_addr, next_addr, next_data, prev_addr, prev_data;
  logic [AW-1:0]         head_next, head_prev;
  logic [AW-1:0]         rd_next, rd_prev;
  logic                  rd_in_use;
  logic [DATA_WIDTH-1:0] rd_value;

  // free pool
  pool_ctl_t             pool;
  logic                  pool_empty;
  logic [AW-1:0]         alloc_node, fresh_lim;

  // decision
  logic                  out_free, ld, do_fin, size_inc, size_dec;
  logic                  in_use_p, h_ok;
  status_t               res_status;
  logic [WORD_W-1:0]     res_data;
  logic [HANDLE_W-1:0]   res_handle;

  dll_node_store #(.POOL_NODES(POOL_NODES), .DATA_WIDTH(DATA_WIDTH)) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (accept),
    .rd_addr    (pos_in),
    .wr         (wr),
    .node_addr  (node_addr),
    .node_value (data_r),
    .next_addr  (next_addr),
    .next_data  (next_data),
    .prev_addr  (prev_addr),
    .prev_data  (prev_data),
    .head_next  (head_next),
    .head_prev  (head_prev),
    .rd_next    (rd_next),
    .rd_prev    (rd_prev),
    .rd_in_use  (rd_in_use),
    .rd_value   (rd_value)
  );

  dll_free_pool #(.POOL_NODES(POOL_NODES)) u_pool (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (pool),
    .push_node  (pos_r),
    .empty      (pool_empty),
    .alloc_node (alloc_node),
    .fresh_lim  (fresh_lim)
  );

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // target node of the request: given handle, the sentinel, or one end of the list
  always_comb begin
    unique case (req_t'(in_req_type)) inside
      REQ_INSERT, REQ_ERASE:       pos_in = AW'(in_node_handle);
      REQ_PUSH_BACK:               pos_in = '0;
      REQ_POP_BACK, REQ_PEEK_BACK: pos_in = head_prev;
      default:                     pos_in = head_next;
    endcase
  end

  // a node above the fresh limit was never allocated, so it is free
  assign in_use_p = rd_in_use && (pos_r <= fresh_lim);
  assign h_ok     = (32'(h_r) < 32'(POOL_NODES)) && in_use_p;

  always_comb begin
    state_nxt  = state_r;
    wr         = '0;
    pool       = '0;
    node_addr  = pos_r;
    next_addr  = '0;
    next_data  = '0;
    prev_addr  = '0;
    prev_data  = '0;
    do_fin     = 1'b0;
    size_inc   = 1'b0;
    size_dec   = 1'b0;
    res_status = ST_OK;
    res_data   = '0;
    res_handle = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_CHK;
      end
      S_CHK: begin
        case (req_r) inside
          REQ_INSERT, REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
            if (req_r == REQ_INSERT && !h_ok) begin
              do_fin     = 1'b1;
              res_status = ST_BAD;
            end else if (pool_empty) begin
              do_fin     = 1'b1;
              res_status = ST_FULL;
            end else begin
              // fresh node: value, in-use bit and its own links
              wr.value_we = 1'b1;
              wr.use_we   = 1'b1;
              wr.use_bit  = 1'b1;
              node_addr   = alloc_node;
              wr.next_we  = 1'b1;
              next_addr   = alloc_node;
              next_data   = pos_r;
              wr.prev_we  = 1'b1;
              prev_addr   = alloc_node;
              prev_data   = rd_prev;
              pool.pop    = 1'b1;
              state_nxt   = S_WR;
            end
          end
          default: begin
            do_fin = 1'b1;
            if (req_r == REQ_ERASE && (!h_ok || h_r == '0)) begin
              res_status = ST_BAD;
            end else if (req_r != REQ_ERASE && (size_r == '0 || pos_r == '0)) begin
              res_status = ST_EMPTY;
            end else begin
              res_data   = WORD_W'(rd_value);
              res_handle = HANDLE_W'(pos_r);
              if (req_r != REQ_PEEK_BACK && req_r != REQ_PEEK_FRONT) begin
                // unlink: both neighbors in the same cycle, different memories
                wr.next_we = 1'b1;
                next_addr  = rd_prev;
                next_data  = rd_next;
                wr.prev_we = 1'b1;
                prev_addr  = rd_next;
                prev_data  = rd_prev;
                wr.use_we  = 1'b1;
                wr.use_bit = 1'b0;
                pool.push  = 1'b1;
                size_dec   = (size_r != '0);
              end
            end
          end
        endcase
      end
      S_WR: begin
        wr.next_we = 1'b1;
        next_addr  = before_r;
        next_data  = n_r;
        wr.prev_we = 1'b1;
        prev_addr  = pos_r;
        prev_data  = n_r;
        size_inc   = 1'b1;
        do_fin     = 1'b1;
        res_handle = HANDLE_W'(n_r);
      end
      default: state_nxt = S_IDLE;
    endcase

    // final step waits for the output register; no side effects meanwhile
    ld = do_fin && out_free;
    if (do_fin && !out_free) begin
      wr        = '0;
      pool      = '0;
      size_inc  = 1'b0;
      size_dec  = 1'b0;
      state_nxt = state_r;
    end else if (do_fin) begin
      state_nxt = S_IDLE;
    end

    size_nxt = size_r + AW'(size_inc) - AW'(size_dec);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      out_valid_r <= ld ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= req_t'(in_req_type);
      h_r    <= in_node_handle;
      data_r <= DATA_WIDTH'(in_data_in);
      pos_r  <= pos_in;
    end
    if (state_r == S_CHK) begin
      n_r      <= alloc_node;
      before_r <= rd_prev;
    end
    if (ld) begin
      out_status_r <= res_status;
      out_data_r   <= res_data;
      out_handle_r <= res_handle;
      out_empty_r  <= (size_nxt == '0);
      out_count_r  <= COUNT_W'(size_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_data_out      = out_data_r;
  assign out_result_handle = out_handle_r;
  assign out_is_empty      = out_empty_r;
  assign out_element_count = out_count_r;

endmodule

// File: rtl/dll_node_store.sv
module dll_node_store #(
  parameter int POOL_NODES = dll_pkg::POOL_NODES_DEF,
  parameter int DATA_WIDTH = dll_pkg::DATA_WIDTH_DEF,
  localparam int AW = $clog2(POOL_NODES)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  input  dll_pkg::wr_t          wr,
  input  logic [AW-1:0]         node_addr,
  input  logic [DATA_WIDTH-1:0] node_value,
  input  logic [AW-1:0]         next_addr,
  input  logic [AW-1:0]         next_data,
  input  logic [AW-1:0]         prev_addr,
  input  logic [AW-1:0]         prev_data,
  output logic [AW-1:0]         head_next,
  output logic [AW-1:0]         head_prev,
  output logic [AW-1:0]         rd_next,
  output logic [AW-1:0]         rd_prev,
  output logic                  rd_in_use,
  output logic [DATA_WIDTH-1:0] rd_value
);
  import dll_pkg::*;

  logic [DATA_WIDTH-1:0] value_mem [POOL_NODES];
  logic [AW-1:0]         next_mem  [POOL_NODES];
  logic [AW-1:0]         prev_mem  [POOL_NODES];
  logic                  use_mem   [POOL_NODES];

  logic [AW-1:0]         rd_addr_r;
  logic [AW-1:0]         rd_next_r;
  logic [AW-1:0]         rd_prev_r;
  logic                  rd_use_r;
  logic [DATA_WIDTH-1:0] rd_value_r;
  logic [AW-1:0]         head_next_r;
  logic [AW-1:0]         head_prev_r;

  // sentinel links live in flops, everything else in memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_next_r <= '0;
      head_prev_r <= '0;
    end else begin
      if (wr.next_we && next_addr == '0) head_next_r <= next_data;
      if (wr.prev_we && prev_addr == '0) head_prev_r <= prev_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.value_we) value_mem[node_addr] <= node_value;
    if (wr.use_we) use_mem[node_addr] <= wr.use_bit;
    if (wr.next_we && next_addr != '0) next_mem[next_addr] <= next_data;
    if (wr.prev_we && prev_addr != '0) prev_mem[prev_addr] <= prev_data;
    if (rd_en) begin
      rd_addr_r  <= rd_addr;
      rd_next_r  <= next_mem[rd_addr];
      rd_prev_r  <= prev_mem[rd_addr];
      rd_use_r   <= use_mem[rd_addr];
      rd_value_r <= value_mem[rd_addr];
    end
  end

  assign head_next = head_next_r;
  assign head_prev = head_prev_r;
  assign rd_next   = (rd_addr_r == '0) ? head_next_r : rd_next_r;
  assign rd_prev   = (rd_addr_r == '0) ? head_prev_r : rd_prev_r;
  assign rd_in_use = (rd_addr_r == '0) ? 1'b1 : rd_use_r;
  assign rd_value  = rd_value_r;

endmodule

// File: rtl/dll_free_pool.sv
module dll_free_pool #(
  parameter int POOL_NODES = dll_pkg::POOL_NODES_DEF,
  localparam int AW = $clog2(POOL_NODES)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dll_pkg::pool_ctl_t ctl,
  input  logic [AW-1:0]      push_node,
  output logic               empty,
  output logic [AW-1:0]      alloc_node,
  output logic [AW-1:0]      fresh_lim
);
  import dll_pkg::*;

  localparam logic [AW-1:0] LAST = AW'(POOL_NODES - 1);

  logic [AW-1:0] stack_mem [POOL_NODES];
  logic [AW-1:0] top_r;
  logic [AW-1:0] lw_r;      // lowest top ever reached: slots below it are untouched
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] rd_idx_r;
  logic [AW-1:0] rd_q_r;

  assign rd_idx = top_r - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= LAST;
      lw_r  <= LAST;
    end else begin
      if (ctl.pop) begin
        top_r <= rd_idx;
        if (rd_idx < lw_r) lw_r <= rd_idx;
      end else if (ctl.push) begin
        top_r <= top_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) stack_mem[top_r] <= push_node;
    rd_idx_r <= rd_idx;
    rd_q_r   <= stack_mem[rd_idx];
  end

  // untouched slot i holds node LAST-i from reset
  assign alloc_node = (rd_idx_r < lw_r) ? LAST - rd_idx_r : rd_q_r;
  assign empty      = (top_r == '0);
  // nodes above this were never handed out
  assign fresh_lim  = LAST - lw_r;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import dll_pkg::*;

  localparam int NODES = POOL_NODES_DEF;

  // one result beat as the block reports it
  typedef struct {
    status_t     status;
    logic [31:0] data;
    logic [7:0]  handle;
    logic        is_empty;
    logic [7:0]  count;
  } list_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_req_type;
  logic [7:0]  in_node_handle;
  logic [31:0] in_data_in;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [31:0] out_data_out;
  logic [7:0]  out_result_handle;
  logic        out_is_empty;
  logic [7:0]  out_element_count;

  doubly_linked_list_engine u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_node_handle    (in_node_handle),
    .in_data_in        (in_data_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_data_out      (out_data_out),
    .out_result_handle (out_result_handle),
    .out_is_empty      (out_is_empty),
    .out_element_count (out_element_count)
  );

  // Shadow copy of the list: node store, links, free stack and element count.
  logic [31:0] node_val [NODES];
  logic [7:0]  nxt      [NODES];
  logic [7:0]  prv      [NODES];
  bit          used     [NODES];
  logic [7:0]  free_stk [NODES-1];
  int          free_cnt;
  int          live_cnt;

  list_result_t results_due[$];  // predicted results, oldest first
  int           errors;
  bit           steady;          // when set, neither side idles

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Result fields track the element count after the request.
  function automatic list_result_t make_result(status_t st, logic [31:0] d, logic [7:0] h);
    list_result_t r;
    r.status   = st;
    r.data     = d;
    r.handle   = h;
    r.is_empty = (live_cnt == 0);
    r.count    = live_cnt[7:0];
    return r;
  endfunction

  // Take the top of the free stack and splice it in ahead of pos.
  function automatic list_result_t link_node(logic [7:0] pos, logic [31:0] d);
    logic [7:0] n;
    logic [7:0] b;
    if (free_cnt == 0) return make_result(ST_FULL, 32'd0, 8'd0);
    free_cnt--;
    n = free_stk[free_cnt];
    b = prv[pos];
    node_val[n] = d;
    used[n]     = 1'b1;
    nxt[b]      = n;
    prv[n]      = b;
    prv[pos]    = n;
    nxt[n]      = pos;
    live_cnt++;
    return make_result(ST_OK, 32'd0, n);
  endfunction

  // Splice pos out and hand it back to the free stack.
  function automatic list_result_t unlink_node(logic [7:0] pos);
    logic [7:0] b;
    logic [7:0] a;
    b = prv[pos];
    a = nxt[pos];
    nxt[b]    = a;
    prv[a]    = b;
    used[pos] = 1'b0;
    if (free_cnt < NODES - 1) begin
      free_stk[free_cnt] = pos;
      free_cnt++;
    end
    if (live_cnt > 0) live_cnt--;
    return make_result(ST_OK, node_val[pos], pos);
  endfunction

  // Apply one request to the shadow list and return the result it should give.
  function automatic list_result_t apply_request(req_t req, logic [7:0] h, logic [31:0] d);
    logic [7:0] tail_end;
    case (req)
      REQ_INSERT: begin
        if (!used[h]) return make_result(ST_BAD, 32'd0, 8'd0);
        return link_node(h, d);
      end
      REQ_ERASE: begin
        // sentinel and free nodes are refused
        if (!used[h] || h == 8'd0) return make_result(ST_BAD, 32'd0, 8'd0);
        return unlink_node(h);
      end
      REQ_PUSH_BACK:  return link_node(8'd0, d);
      REQ_PUSH_FRONT: return link_node(nxt[0], d);
      default: ;
    endcase
    if (live_cnt == 0) return make_result(ST_EMPTY, 32'd0, 8'd0);
    // even codes work at the back, odd codes at the front
    tail_end = req[0] ? nxt[0] : prv[0];
    if (tail_end == 8'd0) return make_result(ST_EMPTY, 32'd0, 8'd0);
    if (req == REQ_POP_BACK || req == REQ_POP_FRONT) return unlink_node(tail_end);
    return make_result(ST_OK, node_val[tail_end], tail_end);
  endfunction

  // Random node currently on the list; the sentinel when the list is empty.
  function automatic logic [7:0] pick_live();
    logic [7:0] p;
    int steps;
    if (live_cnt == 0) return 8'd0;
    p = nxt[0];
    steps = $urandom_range(live_cnt - 1, 0);
    repeat (steps) p = nxt[p];
    return p;
  endfunction

  // Sends one request beat. Called at a rising edge; returns at the edge that
  // accepts it, with valid still high so a following beat can go back to back.
  task automatic send_req(req_t req, logic [7:0] h, logic [31:0] d);
    if (!steady && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_node_handle <= h;
    in_data_in     <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    results_due.push_back(apply_request(req, h, d));
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Result side: random back-pressure, except while steady is set.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 16);
  end

  // Every accepted result beat is matched against the oldest prediction.
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d data 0x%0h handle %0d",
                 $time, out_status, out_data_out, out_result_handle);
        errors++;
      end else begin
        want = results_due.pop_front();
        check_field("status", want.status, out_status);
        check_field("data_out", want.data, out_data_out);
        check_field("result_handle", want.handle, out_result_handle);
        check_field("is_empty", want.is_empty, out_is_empty);
        check_field("element_count", want.count, out_element_count);
      end
    end
  end

  // Pops, peeks, a sentinel erase and requests on free nodes, all on an empty list.
  task automatic test_empty_list();
    send_req(REQ_POP_BACK, 8'd0, 32'd0);
    send_req(REQ_POP_FRONT, 8'd0, 32'd0);
    send_req(REQ_PEEK_BACK, 8'd0, 32'd0);
    send_req(REQ_PEEK_FRONT, 8'd0, 32'd0);
    send_req(REQ_ERASE, 8'd0, 32'd0);
    send_req(REQ_ERASE, 8'd255, 32'd0);
    send_req(REQ_INSERT, 8'd200, 32'hFFFF_FFFF);
  endtask

  // Every operation at least once on a short list, with data extremes.
  task automatic test_list_ops();
    send_req(REQ_PUSH_BACK, 8'd0, 32'd0);
    send_req(REQ_PUSH_FRONT, 8'hFF, 32'hFFFF_FFFF);
    send_req(REQ_INSERT, 8'd0, 32'hA5A5_5A5A);      // before the sentinel: lands at the back
    send_req(REQ_INSERT, nxt[0], 32'h5A5A_A5A5);    // new front
    send_req(REQ_INSERT, prv[prv[0]], $urandom);    // middle of the list
    send_req(REQ_PEEK_FRONT, 8'd0, 32'd0);
    send_req(REQ_PEEK_BACK, 8'd0, 32'd0);
    send_req(REQ_ERASE, nxt[nxt[0]], 32'd0);
    send_req(REQ_ERASE, 8'd0, 32'd0);
    send_req(REQ_POP_BACK, 8'd0, 32'd0);
    send_req(REQ_POP_FRONT, 8'd0, 32'd0);
    send_req(REQ_ERASE, 8'd1, 32'd0);               // node 1 handed out first, still live here
    send_req(REQ_INSERT, 8'd254, 32'd1);            // never allocated
  endtask

  // Fill all 255 nodes, hit the full pool, then drain with random erases and pops.
  task automatic test_pool_full();
    while (free_cnt > 0) send_req(REQ_PUSH_BACK, 8'd0, $urandom);
    send_req(REQ_PUSH_BACK, 8'd0, $urandom);
    send_req(REQ_PUSH_FRONT, 8'd0, $urandom);
    send_req(REQ_INSERT, 8'd0, $urandom);
    send_req(REQ_INSERT, pick_live(), $urandom);
    send_req(REQ_PEEK_BACK, 8'd0, 32'd0);
    // random handles here cover every handle bit, live and freed alike
    while (live_cnt > 0) begin
      case ($urandom_range(3))
        0:       send_req(REQ_ERASE, 8'($urandom_range(255)), $urandom);
        1:       send_req(REQ_POP_BACK, 8'd0, $urandom);
        default: send_req(REQ_POP_FRONT, 8'd0, $urandom);
      endcase
    end
    send_req(REQ_PEEK_FRONT, 8'd0, 32'd0);
  endtask

  // Mostly well-formed requests against live nodes, some noise with raw handles.
  task automatic test_random_traffic(int n_items);
    int roll;
    int grow;
    repeat (n_items) begin
      roll = $urandom_range(99);
      grow = (live_cnt < 48) ? 50 : 30;
      if (roll < 8) begin
        send_req(req_t'($urandom_range(7)), 8'($urandom_range(255)), $urandom);
      end else if (roll < 8 + grow) begin
        case ($urandom_range(2))
          0:       send_req(REQ_PUSH_BACK, 8'($urandom_range(255)), $urandom);
          1:       send_req(REQ_PUSH_FRONT, 8'($urandom_range(255)), $urandom);
          default: send_req(REQ_INSERT, ($urandom_range(3) == 0) ? 8'd0 : pick_live(), $urandom);
        endcase
      end else begin
        case ($urandom_range(4))
          0:       send_req(REQ_ERASE, pick_live(), $urandom);
          1:       send_req(REQ_POP_BACK, 8'd0, $urandom);
          2:       send_req(REQ_POP_FRONT, 8'd0, $urandom);
          3:       send_req(REQ_PEEK_BACK, 8'd0, $urandom);
          default: send_req(REQ_PEEK_FRONT, 8'd0, $urandom);
        endcase
      end
    end
  endtask

  // Full-rate stretch: no gaps on either side.
  task automatic test_back_to_back();
    steady = 1'b1;
    test_random_traffic(60);
    steady = 1'b0;
  endtask

  initial begin
    errors         = 0;
    steady         = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = REQ_INSERT;
    in_node_handle = 8'd0;
    in_data_in     = 32'd0;

    // shadow list after reset: only the sentinel, node 1 on top of the free stack
    for (int i = 0; i < NODES; i++) begin
      node_val[i] = 32'd0;
      nxt[i]      = 8'd0;
      prv[i]      = 8'd0;
      used[i]     = (i == 0);
    end
    for (int i = 0; i < NODES - 1; i++) free_stk[i] = 8'(NODES - 1 - i);
    free_cnt = NODES - 1;
    live_cnt = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_list_ops();
    test_pool_full();
    test_random_traffic(220);
    test_back_to_back();

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);   // catch any stray result
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
